FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the splitter RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// prop must hold at every clock edge outside reset
`define STCS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// cond must never be true outside reset
`define STCS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define STCS_ASSERT(lbl, clk, rst_n, prop, msg)

`define STCS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

FILE: hw/rtl/stcs_pkg.sv
// ---------------------------------------------------------------------------
// stcs_pkg
// Widths, register indexes, reset values and shared types of the splitter.
// ---------------------------------------------------------------------------
package stcs_pkg;

	localparam int LEN_W        = 24;
	localparam int ADDR_W       = 17;
	localparam int FN_W         = 3;
	localparam int BS_W         = 12;
	localparam int HBC_W        = 16;
	localparam int SEG_W        = 21;
	localparam int BLK_W        = 9;
	localparam int LIM_W        = 10;
	localparam int CHUNK_W      = BLK_W + BS_W;
	localparam int MAX_COMMANDS = 64;
	localparam int CNT_W        = $clog2(MAX_COMMANDS + 1);
	localparam int DIV_CNT_W    = $clog2(LEN_W);

	localparam int CFG_W     = SEG_W;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MULTI_BLOCK     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOST_BLK_COUNT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HOST_SEG_SIZE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HOST_BLK_SIZE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_FUNC_BLK_SIZE   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_BYTE_USES_BS    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_BROKEN_BYTE_512 = 3'd7;

	localparam logic [BS_W-1:0]  RST_BLOCK_SIZE     = 12'd512;
	localparam logic [HBC_W-1:0] RST_HOST_BLK_COUNT = 16'd511;
	localparam logic [SEG_W-1:0] RST_HOST_SEG_SIZE  = 21'd65536;
	localparam logic [BS_W-1:0]  RST_HOST_BLK_SIZE  = 12'd512;
	localparam logic [BS_W-1:0]  RST_FUNC_BLK_SIZE  = 12'd512;

	localparam logic [SEG_W-1:0] BYTE_CAP        = 21'd512;
	localparam logic [SEG_W-1:0] BYTE_CAP_BROKEN = 21'd511;
	localparam logic [BLK_W-1:0] BLOCK_CAP       = 9'd511;

	localparam int SEL_W = 2;
	localparam logic [SEL_W-1:0] SEL_BYTE = 2'd0;
	localparam logic [SEL_W-1:0] SEL_FULL = 2'd1;
	localparam logic [SEL_W-1:0] SEL_DIV  = 2'd2;

	typedef struct packed {
		logic              is_write;
		logic [FN_W-1:0]   function_number;
		logic [ADDR_W-1:0] start_address;
		logic              increment_address;
		logic [LEN_W-1:0]  total_bytes;
	} req_t;

	typedef struct packed {
		logic              cmd_is_write;
		logic [FN_W-1:0]   cmd_function;
		logic [ADDR_W-1:0] cmd_address;
		logic              cmd_increment;
		logic [BLK_W-1:0]  cmd_block_count;
		logic [BS_W-1:0]   cmd_length;
		logic              last_command;
		logic              overflow_error;
	} cmd_t;

	typedef struct packed {
		logic             load_req;
		logic             div_seg_start;
		logic             div_rem_start;
		logic             set_bpc;
		logic             set_chunk;
		logic             load_cmd;
		logic [SEL_W-1:0] cmd_sel;
	} ctrl_t;

	typedef struct packed {
		logic req_zero;
		logic use_blocks;
		logic block_ok;
		logic full_fits;
		logic div_done;
		logic last_cmd;
	} stat_t;

endpackage

FILE: hw/rtl/stcs_if.sv
// ---------------------------------------------------------------------------
// stcs_if
// Valid/ready channels for requests and commands.
// ---------------------------------------------------------------------------
interface stcs_req_if;
	logic                          valid;
	logic                          ready;
	logic                          is_write;
	logic [stcs_pkg::FN_W-1:0]     function_number;
	logic [stcs_pkg::ADDR_W-1:0]   start_address;
	logic                          increment_address;
	logic [stcs_pkg::LEN_W-1:0]    total_bytes;

	modport source (output valid, is_write, function_number, start_address,
		increment_address, total_bytes, input ready);
	modport sink (input valid, is_write, function_number, start_address,
		increment_address, total_bytes, output ready);
endinterface

interface stcs_cmd_if;
	logic                          valid;
	logic                          ready;
	logic                          cmd_is_write;
	logic [stcs_pkg::FN_W-1:0]     cmd_function;
	logic [stcs_pkg::ADDR_W-1:0]   cmd_address;
	logic                          cmd_increment;
	logic [stcs_pkg::BLK_W-1:0]    cmd_block_count;
	logic [stcs_pkg::BS_W-1:0]     cmd_length;
	logic                          last_command;
	logic                          overflow_error;

	modport source (output valid, cmd_is_write, cmd_function, cmd_address,
		cmd_increment, cmd_block_count, cmd_length, last_command,
		overflow_error, input ready);
	modport sink (input valid, cmd_is_write, cmd_function, cmd_address,
		cmd_increment, cmd_block_count, cmd_length, last_command,
		overflow_error, output ready);
endinterface

FILE: hw/rtl/stcs_div.sv
// ---------------------------------------------------------------------------
// stcs_div
// Restoring divider, one quotient bit per cycle, done pulse at the end.
// ---------------------------------------------------------------------------
module stcs_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [stcs_pkg::LEN_W-1:0]   dividend,
	input  logic [stcs_pkg::BS_W-1:0]    divisor,
	output logic                         done,
	output logic [stcs_pkg::LEN_W-1:0]   quotient,
	output logic [stcs_pkg::BS_W-1:0]    remainder
);
	import stcs_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [LEN_W-1:0]     quo_q;
	logic [BS_W-1:0]      rem_q;
	logic [BS_W-1:0]      div_q;
	logic [BS_W:0]        trial;
	logic [BS_W:0]        diff;
	logic                 ge;

	assign trial = {rem_q, quo_q[LEN_W-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			div_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				quo_q  <= dividend;
				rem_q  <= '0;
				div_q  <= divisor;
			end else if (busy_q) begin
				quo_q <= {quo_q[LEN_W-2:0], ge};
				rem_q <= ge ? diff[BS_W-1:0] : trial[BS_W-1:0];
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(LEN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

FILE: hw/rtl/stcs_datapath.sv
// ---------------------------------------------------------------------------
// stcs_datapath
// Configuration registers, request state, limits and the command register.
// ---------------------------------------------------------------------------
module stcs_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [stcs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [stcs_pkg::CFG_W-1:0]       cfg_data,
	input  stcs_pkg::req_t                   req,
	input  stcs_pkg::ctrl_t                  ctrl,
	output stcs_pkg::stat_t                  stat,
	output stcs_pkg::cmd_t                   cmd
);
	import stcs_pkg::*;

	// configuration
	logic [BS_W-1:0]   bs_q;
	logic              mbe_q;
	logic [HBC_W-1:0]  hbc_q;
	logic [SEG_W-1:0]  seg_q;
	logic [BS_W-1:0]   hbs_q;
	logic [BS_W-1:0]   fbs_q;
	logic              byte_bs_q;
	logic              broken_q;

	// request state
	logic              wr_q;
	logic [FN_W-1:0]   fn_q;
	logic              incr_q;
	logic [ADDR_W-1:0] addr_q;
	logic [LEN_W-1:0]  rem_q;
	logic [BLK_W-1:0]  bpc_q;
	logic [CHUNK_W-1:0] chunk_q;
	logic [LIM_W-1:0]  lim_q;
	logic [CNT_W-1:0]  count_q;
	cmd_t              cmd_q;

	// divider
	logic              div_start;
	logic [LEN_W-1:0]  div_dividend;
	logic              div_done;
	logic [LEN_W-1:0]  div_quo;
	logic [BS_W-1:0]   div_rem;

	// limits
	logic [SEG_W-1:0]  lim_a;
	logic [SEG_W-1:0]  lim_b;
	logic [SEG_W-1:0]  lim_c;
	logic [BS_W-1:0]   lim_sel;
	logic [SEG_W-1:0]  cap;
	logic [LIM_W-1:0]  byte_lim;
	logic [LEN_W-1:0]  mb_a;
	logic [LEN_W-1:0]  mb_b;
	logic [BLK_W-1:0]  max_blk;

	// command step
	logic [LIM_W-1:0]  byte_len;
	logic [BLK_W-1:0]  blocks;
	logic [BS_W-1:0]   len;
	logic [LEN_W-1:0]  moved;
	logic [LEN_W-1:0]  rem_nxt;
	logic [CNT_W-1:0]  count_nxt;
	logic [ADDR_W-1:0] addr_nxt;
	logic              last_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_q      <= RST_BLOCK_SIZE;
			mbe_q     <= 1'b0;
			hbc_q     <= RST_HOST_BLK_COUNT;
			seg_q     <= RST_HOST_SEG_SIZE;
			hbs_q     <= RST_HOST_BLK_SIZE;
			fbs_q     <= RST_FUNC_BLK_SIZE;
			byte_bs_q <= 1'b0;
			broken_q  <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_BLOCK_SIZE:      bs_q      <= cfg_data[BS_W-1:0];
				CFG_MULTI_BLOCK:     mbe_q     <= cfg_data[0];
				CFG_HOST_BLK_COUNT:  hbc_q     <= cfg_data[HBC_W-1:0];
				CFG_HOST_SEG_SIZE:   seg_q     <= cfg_data[SEG_W-1:0];
				CFG_HOST_BLK_SIZE:   hbs_q     <= cfg_data[BS_W-1:0];
				CFG_FUNC_BLK_SIZE:   fbs_q     <= cfg_data[BS_W-1:0];
				CFG_BYTE_USES_BS:    byte_bs_q <= cfg_data[0];
				CFG_BROKEN_BYTE_512: broken_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// byte-mode chunk limit, zero means one
	always_comb begin
		lim_sel  = byte_bs_q ? bs_q : fbs_q;
		cap      = broken_q ? BYTE_CAP_BROKEN : BYTE_CAP;
		lim_a    = (seg_q < SEG_W'(hbs_q)) ? seg_q : SEG_W'(hbs_q);
		lim_b    = (lim_a < SEG_W'(lim_sel)) ? lim_a : SEG_W'(lim_sel);
		lim_c    = (lim_b < cap) ? lim_b : cap;
		byte_lim = (lim_c == '0) ? LIM_W'(1) : lim_c[LIM_W-1:0];
	end

	// blocks per command from segment / block size, zero means one
	always_comb begin
		mb_a    = (div_quo < LEN_W'(hbc_q)) ? div_quo : LEN_W'(hbc_q);
		mb_b    = (mb_a < LEN_W'(BLOCK_CAP)) ? mb_a : LEN_W'(BLOCK_CAP);
		max_blk = (mb_b == '0) ? BLK_W'(1) : mb_b[BLK_W-1:0];
	end

	assign div_start    = ctrl.div_seg_start | ctrl.div_rem_start;
	assign div_dividend = ctrl.div_rem_start ? rem_q : LEN_W'(seg_q);

	stcs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (bs_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_comb begin
		byte_len = (rem_q < LEN_W'(lim_q)) ? rem_q[LIM_W-1:0] : lim_q;
		case (ctrl.cmd_sel)
			SEL_FULL: begin
				blocks = bpc_q;
				len    = bs_q;
				moved  = LEN_W'(chunk_q);
			end
			SEL_DIV: begin
				blocks = div_quo[BLK_W-1:0];
				len    = bs_q;
				moved  = rem_q - LEN_W'(div_rem);
			end
			default: begin
				blocks = '0;
				len    = BS_W'(byte_len);
				moved  = LEN_W'(byte_len);
			end
		endcase
		rem_nxt   = rem_q - moved;
		count_nxt = count_q + CNT_W'(1);
		addr_nxt  = incr_q ? addr_q + moved[ADDR_W-1:0] : addr_q;
		last_nxt  = (rem_nxt == '0) || (count_nxt == CNT_W'(MAX_COMMANDS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			fn_q    <= '0;
			incr_q  <= 1'b0;
			addr_q  <= '0;
			rem_q   <= '0;
			bpc_q   <= '0;
			chunk_q <= '0;
			lim_q   <= '0;
			count_q <= '0;
			cmd_q   <= '0;
		end else begin
			if (ctrl.load_req) begin
				wr_q    <= req.is_write;
				fn_q    <= req.function_number;
				incr_q  <= req.increment_address;
				addr_q  <= req.start_address;
				rem_q   <= req.total_bytes;
				bpc_q   <= '0;
				lim_q   <= byte_lim;
				count_q <= '0;
			end
			if (ctrl.set_bpc) begin
				bpc_q <= max_blk;
			end
			if (ctrl.set_chunk) begin
				chunk_q <= CHUNK_W'(bpc_q) * CHUNK_W'(bs_q);
			end
			if (ctrl.load_cmd) begin
				cmd_q.cmd_is_write    <= wr_q;
				cmd_q.cmd_function    <= fn_q;
				cmd_q.cmd_address     <= addr_q;
				cmd_q.cmd_increment   <= incr_q;
				cmd_q.cmd_block_count <= blocks;
				cmd_q.cmd_length      <= len;
				cmd_q.last_command    <= last_nxt;
				cmd_q.overflow_error  <= last_nxt && (rem_nxt != '0);
				rem_q   <= rem_nxt;
				addr_q  <= addr_nxt;
				count_q <= count_nxt;
			end
		end
	end

	always_comb begin
		stat.req_zero   = req.total_bytes == '0;
		stat.use_blocks = mbe_q && (bs_q != '0) && (req.total_bytes > LEN_W'(byte_lim));
		stat.block_ok   = (bpc_q != '0) && (rem_q >= LEN_W'(bs_q));
		stat.full_fits  = rem_q >= LEN_W'(chunk_q);
		stat.div_done   = div_done;
		stat.last_cmd   = cmd_q.last_command;
	end

	assign cmd = cmd_q;

endmodule

FILE: hw/rtl/stcs_ctrl.sv
// ---------------------------------------------------------------------------
// stcs_ctrl
// Sequencer: request load, block planning, one command per step.
// ---------------------------------------------------------------------------
module stcs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              out_ready,
	input  stcs_pkg::stat_t   stat,
	output logic              in_ready,
	output logic              out_valid,
	output stcs_pkg::ctrl_t   ctrl
);
	import stcs_pkg::*;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_DIV_SEG = 3'd1;
	localparam logic [2:0] S_MUL     = 3'd2;
	localparam logic [2:0] S_STEP    = 3'd3;
	localparam logic [2:0] S_DIV_REM = 3'd4;
	localparam logic [2:0] S_EMIT    = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		ctrl      = '0;
		state_nxt = state_q;
		in_ready  = state_q == S_IDLE;
		out_valid = state_q == S_EMIT;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctrl.load_req = 1'b1;
					if (!stat.req_zero) begin
						if (stat.use_blocks) begin
							ctrl.div_seg_start = 1'b1;
							state_nxt          = S_DIV_SEG;
						end else begin
							state_nxt = S_STEP;
						end
					end
				end
			end
			S_DIV_SEG: begin
				if (stat.div_done) begin
					ctrl.set_bpc = 1'b1;
					state_nxt    = S_MUL;
				end
			end
			S_MUL: begin
				ctrl.set_chunk = 1'b1;
				state_nxt      = S_STEP;
			end
			S_STEP: begin
				if (stat.block_ok && !stat.full_fits) begin
					ctrl.div_rem_start = 1'b1;
					state_nxt          = S_DIV_REM;
				end else begin
					ctrl.load_cmd = 1'b1;
					ctrl.cmd_sel  = stat.block_ok ? SEL_FULL : SEL_BYTE;
					state_nxt     = S_EMIT;
				end
			end
			S_DIV_REM: begin
				if (stat.div_done) begin
					ctrl.load_cmd = 1'b1;
					ctrl.cmd_sel  = SEL_DIV;
					state_nxt     = S_EMIT;
				end
			end
			S_EMIT: begin
				if (out_ready) begin
					state_nxt = stat.last_cmd ? S_IDLE : S_STEP;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

FILE: hw/rtl/sdio_transfer_command_splitter.sv
// ---------------------------------------------------------------------------
// sdio_transfer_command_splitter
// Splits one extended-transfer request into a run of extended commands.
// ---------------------------------------------------------------------------
// Channels: req (sink) takes one request per transfer; cmd (source) gives one
// extended command per transfer, last_command set on the final one and
// overflow_error set with it when the 64-command limit cut the request short.
// Configuration: cfg_write/cfg_index/cfg_data write one register per cycle.
// Write only while no request is in progress; the block does not enforce it.
// Flow: one request at a time; req.ready is high only when idle. A request
// with block mode first runs the segment/block-size division and one 9x12
// multiply. Each command then passes through the step and present states,
// and the one partial block-mode command also waits on remaining/block-size
// from the shared restoring divider.
// Zero-length requests are accepted and give no command.
// The command register holds while cmd.ready is low; nothing advances.
// Reset: asynchronous, active low; config returns to its defaults, the
// block goes idle and any partial request is dropped.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sdio_transfer_command_splitter (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [stcs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [stcs_pkg::CFG_W-1:0]       cfg_data,
	stcs_req_if.sink                         req,
	stcs_cmd_if.source                       cmd
);
	import stcs_pkg::*;

	req_t  req_in;
	cmd_t  cmd_out;
	ctrl_t ctrl;
	stat_t stat;
	logic  in_ready;
	logic  out_valid;

	assign req_in.is_write          = req.is_write;
	assign req_in.function_number   = req.function_number;
	assign req_in.start_address     = req.start_address;
	assign req_in.increment_address = req.increment_address;
	assign req_in.total_bytes       = req.total_bytes;

	stcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.out_ready (cmd.ready),
		.stat      (stat),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.ctrl      (ctrl)
	);

	stcs_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_in),
		.ctrl      (ctrl),
		.stat      (stat),
		.cmd       (cmd_out)
	);

	assign req.ready           = in_ready;
	assign cmd.valid           = out_valid;
	assign cmd.cmd_is_write    = cmd_out.cmd_is_write;
	assign cmd.cmd_function    = cmd_out.cmd_function;
	assign cmd.cmd_address     = cmd_out.cmd_address;
	assign cmd.cmd_increment   = cmd_out.cmd_increment;
	assign cmd.cmd_block_count = cmd_out.cmd_block_count;
	assign cmd.cmd_length      = cmd_out.cmd_length;
	assign cmd.last_command    = cmd_out.last_command;
	assign cmd.overflow_error  = cmd_out.overflow_error;

	`STCS_ASSERT_NEVER(a_idle_xor_emit, clk, arst_n, in_ready && out_valid, "accepting while a command is pending")
	`STCS_ASSERT(a_ovf_is_last, clk, arst_n, (out_valid && cmd_out.overflow_error) |-> cmd_out.last_command, "overflow flagged on a non-final command")
	`STCS_ASSERT(a_len_nonzero, clk, arst_n, out_valid |-> (cmd_out.cmd_length != '0), "command with zero length")
	`STCS_ASSERT(a_load_presents, clk, arst_n, ctrl.load_cmd |=> out_valid, "loaded command not presented")

endmodule

FILE: sim/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the SDIO transfer command splitter.
// ---------------------------------------------------------------------------
// Requests go in over the request channel. A scoreboard predicts the split
// of each accepted request into extended commands from its own copy of the
// registers. Every command transfer is checked field by field against the
// oldest prediction. Register settings change between phases, only while
// the block is idle. The command side stalls in random bursts. The request
// side pauses in random bursts too.
// ---------------------------------------------------------------------------
module tb;
	import stcs_pkg::*;

	typedef int unsigned cfg_set_t [8];

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	bit stall_on;
	bit send_idle;
	bit quiet;

	stcs_req_if req_ch ();
	stcs_cmd_if cmd_ch ();

	sdio_transfer_command_splitter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.cmd       (cmd_ch)
	);

	class cmd_tracker;
		int unsigned cfg [8];
		cmd_t        pending_cmds [$];
		int          errors;
		int          requests;
		int          cmds;
		int          block_cmds;
		int          cut_requests;
		int          settings;

		function new();
			cfg[CFG_BLOCK_SIZE]      = RST_BLOCK_SIZE;
			cfg[CFG_MULTI_BLOCK]     = 0;
			cfg[CFG_HOST_BLK_COUNT]  = RST_HOST_BLK_COUNT;
			cfg[CFG_HOST_SEG_SIZE]   = RST_HOST_SEG_SIZE;
			cfg[CFG_HOST_BLK_SIZE]   = RST_HOST_BLK_SIZE;
			cfg[CFG_FUNC_BLK_SIZE]   = RST_FUNC_BLK_SIZE;
			cfg[CFG_BYTE_USES_BS]    = 0;
			cfg[CFG_BROKEN_BYTE_512] = 0;
		endfunction

		function void set_reg(int idx, int unsigned v);
			case (idx)
				CFG_BLOCK_SIZE, CFG_HOST_BLK_SIZE, CFG_FUNC_BLK_SIZE: cfg[idx] = v & 'hFFF;
				CFG_HOST_BLK_COUNT: cfg[idx] = v & 'hFFFF;
				CFG_HOST_SEG_SIZE:  cfg[idx] = v & 'h1FFFFF;
				default:            cfg[idx] = v & 1;
			endcase
		endfunction

		function void note_request(req_t r);
			int unsigned left;
			int unsigned addr;
			int unsigned lim;
			int unsigned bpc;
			int unsigned blocks;
			int unsigned len;
			int unsigned moved;
			int unsigned bs;
			int unsigned n;
			cmd_t        c;
			bs   = cfg[CFG_BLOCK_SIZE];
			left = r.total_bytes;
			addr = r.start_address;
			lim  = cfg[CFG_HOST_SEG_SIZE];
			if (cfg[CFG_HOST_BLK_SIZE] < lim) lim = cfg[CFG_HOST_BLK_SIZE];
			if (cfg[CFG_BYTE_USES_BS] != 0) begin
				if (bs < lim) lim = bs;
			end else if (cfg[CFG_FUNC_BLK_SIZE] < lim) begin
				lim = cfg[CFG_FUNC_BLK_SIZE];
			end
			if (cfg[CFG_BROKEN_BYTE_512] != 0) begin
				if (BYTE_CAP_BROKEN < lim) lim = BYTE_CAP_BROKEN;
			end else if (BYTE_CAP < lim) begin
				lim = BYTE_CAP;
			end
			if (lim == 0) lim = 1;
			bpc = 0;
			if (cfg[CFG_MULTI_BLOCK] != 0 && bs != 0 && left > lim) begin
				bpc = cfg[CFG_HOST_SEG_SIZE] / bs;
				if (cfg[CFG_HOST_BLK_COUNT] < bpc) bpc = cfg[CFG_HOST_BLK_COUNT];
				if (BLOCK_CAP < bpc) bpc = BLOCK_CAP;
				if (bpc == 0) bpc = 1;
			end
			n = 0;
			requests++;
			while (left != 0 && n < MAX_COMMANDS) begin
				if (bpc != 0 && left >= bs) begin
					blocks = left / bs;
					if (blocks > bpc) blocks = bpc;
					len   = bs;
					moved = blocks * bs;
				end else begin
					blocks = 0;
					len    = (left < lim) ? left : lim;
					moved  = len;
				end
				c.cmd_is_write    = r.is_write;
				c.cmd_function    = r.function_number;
				c.cmd_address     = addr[ADDR_W-1:0];
				c.cmd_increment   = r.increment_address;
				c.cmd_block_count = blocks[BLK_W-1:0];
				c.cmd_length      = len[BS_W-1:0];
				left -= moved;
				if (r.increment_address) addr = (addr + moved) & 'h1FFFF;
				n++;
				c.last_command   = (left == 0) || (n >= MAX_COMMANDS);
				c.overflow_error = (left != 0) && c.last_command;
				pending_cmds.push_back(c);
			end
		endfunction

		task report(string msg);
			errors++;
			$display("%0t mismatch: %s", $time, msg);
		endtask

		task field_check(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want)
				report($sformatf("cmd %0d %s got %0h want %0h", cmds, name, got, want));
		endtask

		task check_cmd(cmd_t got);
			cmd_t want;
			if (pending_cmds.size() == 0) begin
				report("command transfer with nothing expected");
				return;
			end
			want = pending_cmds.pop_front();
			field_check("cmd_is_write", got.cmd_is_write, want.cmd_is_write);
			field_check("cmd_function", got.cmd_function, want.cmd_function);
			field_check("cmd_address", got.cmd_address, want.cmd_address);
			field_check("cmd_increment", got.cmd_increment, want.cmd_increment);
			field_check("cmd_block_count", got.cmd_block_count, want.cmd_block_count);
			field_check("cmd_length", got.cmd_length, want.cmd_length);
			field_check("last_command", got.last_command, want.last_command);
			field_check("overflow_error", got.overflow_error, want.overflow_error);
			cmds++;
			if (want.cmd_block_count != 0) block_cmds++;
			if (want.overflow_error) cut_requests++;
		endtask
	endclass

	cmd_tracker sb;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("[sdio_transfer_command_splitter] ERROR");
		$finish;
	end

	initial begin
		cmd_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_on && !quiet && $urandom_range(0, 5) == 0) begin
				cmd_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			cmd_ch.ready <= 1'b1;
		end
	end

	initial begin
		cmd_t got;
		forever begin
			@(posedge clk);
			if (arst_n && cmd_ch.valid && cmd_ch.ready) begin
				got.cmd_is_write    = cmd_ch.cmd_is_write;
				got.cmd_function    = cmd_ch.cmd_function;
				got.cmd_address     = cmd_ch.cmd_address;
				got.cmd_increment   = cmd_ch.cmd_increment;
				got.cmd_block_count = cmd_ch.cmd_block_count;
				got.cmd_length      = cmd_ch.cmd_length;
				got.last_command    = cmd_ch.last_command;
				got.overflow_error  = cmd_ch.overflow_error;
				sb.check_cmd(got);
			end
		end
	end

	function automatic req_t mk(bit wr, int fn, int unsigned addr, bit incr, int unsigned len);
		req_t r;
		r.is_write          = wr;
		r.function_number   = fn[FN_W-1:0];
		r.start_address     = addr[ADDR_W-1:0];
		r.increment_address = incr;
		r.total_bytes       = len[LEN_W-1:0];
		return r;
	endfunction

	function automatic int unsigned pick_size();
		case ($urandom_range(0, 4))
			0:       return 1;
			1:       return 2048;
			2:       return 1 << $urandom_range(0, 11);
			default: return $urandom_range(1, 2048);
		endcase
	endfunction

	function automatic cfg_set_t random_cfg();
		cfg_set_t c;
		c[CFG_BLOCK_SIZE] = pick_size();
		c[CFG_MULTI_BLOCK] = ($urandom_range(0, 3) != 0);
		case ($urandom_range(0, 3))
			0:       c[CFG_HOST_BLK_COUNT] = 1;
			1:       c[CFG_HOST_BLK_COUNT] = 65535;
			2:       c[CFG_HOST_BLK_COUNT] = $urandom_range(1, 600);
			default: c[CFG_HOST_BLK_COUNT] = $urandom_range(1, 65535);
		endcase
		case ($urandom_range(0, 3))
			0:       c[CFG_HOST_SEG_SIZE] = 1;
			1:       c[CFG_HOST_SEG_SIZE] = 1048576;
			2:       c[CFG_HOST_SEG_SIZE] = $urandom_range(1, 4096);
			default: c[CFG_HOST_SEG_SIZE] = $urandom_range(1, 1048576);
		endcase
		c[CFG_HOST_BLK_SIZE] = pick_size();
		c[CFG_FUNC_BLK_SIZE] = pick_size();
		c[CFG_BYTE_USES_BS] = $urandom_range(0, 1);
		c[CFG_BROKEN_BYTE_512] = $urandom_range(0, 1);
		return c;
	endfunction

	function automatic cfg_set_t reset_cfg();
		cfg_set_t c;
		c[CFG_BLOCK_SIZE]      = RST_BLOCK_SIZE;
		c[CFG_MULTI_BLOCK]     = 0;
		c[CFG_HOST_BLK_COUNT]  = RST_HOST_BLK_COUNT;
		c[CFG_HOST_SEG_SIZE]   = RST_HOST_SEG_SIZE;
		c[CFG_HOST_BLK_SIZE]   = RST_HOST_BLK_SIZE;
		c[CFG_FUNC_BLK_SIZE]   = RST_FUNC_BLK_SIZE;
		c[CFG_BYTE_USES_BS]    = 0;
		c[CFG_BROKEN_BYTE_512] = 0;
		return c;
	endfunction

	function automatic req_t random_request();
		int unsigned addr;
		int unsigned len;
		int unsigned bs;
		bs = sb.cfg[CFG_BLOCK_SIZE];
		if ($urandom_range(0, 3) == 0) addr = $urandom_range('h1FF00, 'h1FFFF);
		else addr = $urandom_range(0, 'h1FFFF);
		case ($urandom_range(0, 19))
			0, 1:          len = $urandom_range(0, 3);
			2, 3, 4, 5, 6: len = $urandom_range(1, 1100);
			7, 8, 9, 10, 11, 12: len = $urandom_range(1, 70000);
			13, 14:        len = $urandom & 'hFFFFFF;
			default:       len = (($urandom_range(1, 600) * bs + $urandom_range(0, 2)) - 1)
			                     & 'hFFFFFF;
		endcase
		return mk($urandom_range(0, 1), $urandom_range(0, 7), addr,
			$urandom_range(0, 3) != 0, len);
	endfunction

	task automatic send_request(input req_t r);
		if (send_idle && !quiet && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		req_ch.valid             <= 1'b1;
		req_ch.is_write          <= r.is_write;
		req_ch.function_number   <= r.function_number;
		req_ch.start_address     <= r.start_address;
		req_ch.increment_address <= r.increment_address;
		req_ch.total_bytes       <= r.total_bytes;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(r);
	endtask

	// zero-length requests leave nothing to wait for; a trailing idle wait covers them
	task automatic settle();
		req_ch.valid <= 1'b0;
		while (sb.pending_cmds.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic program_config(input cfg_set_t vals);
		int i;
		for (i = 0; i < 8; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= i[CFG_IDX_W-1:0];
			cfg_data  <= vals[i][CFG_W-1:0];
			@(posedge clk);
			sb.set_reg(i, vals[i]);
		end
		cfg_write <= 1'b0;
		sb.settings++;
	endtask

	initial begin
		cfg_set_t c;
		int       p;
		int       k;
		sb = new();
		arst_n                   <= 1'b0;
		cfg_write                <= 1'b0;
		cfg_index                <= CFG_BLOCK_SIZE;
		cfg_data                 <= '0;
		req_ch.valid             <= 1'b0;
		req_ch.is_write          <= 1'b0;
		req_ch.function_number   <= '0;
		req_ch.start_address     <= '0;
		req_ch.increment_address <= 1'b0;
		req_ch.total_bytes       <= '0;
		stall_on  = 1'b1;
		send_idle = 1'b1;
		quiet     = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: byte mode only
		send_request(mk(0, 0, 0, 1, 0));
		send_request(mk(1, 7, 'h1FFFF, 1, 1));
		send_request(mk(0, 3, 'h1FF00, 1, 1000));
		send_request(mk(1, 5, 100, 0, 1537));
		send_request(mk(0, 0, 0, 1, 'hFFFFFF));
		settle();

		c = reset_cfg();
		c[CFG_MULTI_BLOCK] = 1;
		program_config(c);
		send_request(mk(1, 1, 0, 1, 512));
		send_request(mk(0, 2, 'h1FFFF, 1, 513));
		send_request(mk(1, 6, 1234, 0, 511 * 512 * 2 + 300));
		send_request(mk(0, 7, 0, 1, 'hFFFFFF));
		send_request(mk(1, 0, 5, 1, 0));
		settle();

		c[CFG_BLOCK_SIZE]      = 2048;
		c[CFG_HOST_BLK_COUNT]  = 65535;
		c[CFG_HOST_SEG_SIZE]   = 1048576;
		c[CFG_HOST_BLK_SIZE]   = 2048;
		c[CFG_FUNC_BLK_SIZE]   = 2048;
		c[CFG_BYTE_USES_BS]    = 1;
		c[CFG_BROKEN_BYTE_512] = 1;
		program_config(c);
		send_request(mk(0, 4, 77, 1, 2048));
		send_request(mk(1, 3, 'h1F000, 1, 2049));
		send_request(mk(0, 2, 9, 1, 511 * 2048 + 7));
		send_request(mk(1, 1, 'h10000, 0, 'hFFFFFF));
		send_request(mk(0, 6, 3, 1, 511));
		settle();

		// segment below block size: block count clamps to one
		c = reset_cfg();
		c[CFG_MULTI_BLOCK]    = 1;
		c[CFG_BLOCK_SIZE]     = 2048;
		c[CFG_HOST_SEG_SIZE]  = 1000;
		c[CFG_HOST_BLK_COUNT] = 1;
		program_config(c);
		send_request(mk(1, 2, 'h1FFF0, 1, 5000));
		send_request(mk(0, 5, 40, 1, 2048));
		settle();

		// zero block size: no block mode, byte limit of one
		c[CFG_BLOCK_SIZE]   = 0;
		c[CFG_BYTE_USES_BS] = 1;
		program_config(c);
		send_request(mk(0, 1, 10, 1, 3));
		send_request(mk(1, 7, 'h1FFFE, 1, 70));
		settle();

		for (p = 0; p < 10; p++) begin
			c = random_cfg();
			quiet     = (p == 9);
			stall_on  = ($urandom_range(0, 3) != 0);
			send_idle = ($urandom_range(0, 3) != 0);
			program_config(c);
			for (k = 0; k < 31; k++) begin
				if (!quiet && (k == 15 || $urandom_range(0, 24) == 0)) settle();
				send_request(random_request());
			end
			settle();
		end

		repeat (20) @(posedge clk);
		if (sb.pending_cmds.size() != 0)
			sb.report($sformatf("%0d commands never arrived", sb.pending_cmds.size()));
		$display("covered %0d requests, %0d commands (%0d block mode, %0d cut at the limit)",
			sb.requests, sb.cmds, sb.block_cmds, sb.cut_requests);
		$display("over %0d register settings, %0d mismatches", sb.settings, sb.errors);
		if (sb.errors == 0)
			$display("[sdio_transfer_command_splitter] OK");
		else
			$display("[sdio_transfer_command_splitter] ERROR");
		$finish;
	end
endmodule
